// ----- hdl/rcis_pkg.sv -----
package rcis_pkg;

    // Memory and register file geometry
    localparam int MEM_WORDS = 2048;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_MASK = 32'(MEM_WORDS - 1);
    localparam int NUM_REGS  = 32;
    localparam int RF_AW     = $clog2(NUM_REGS);

    // Field widths fixed by the stream format
    localparam int PLEN_W    = 12;
    localparam int IDX_W     = 11;
    localparam int SHAMT_LIMIT = 32;

    // Result queue; depth is a power of two
    localparam int OFIFO_DEPTH = 2;
    localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);
    localparam int CNT_W       = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_MOVI  = 4'd3,
        OP_JEQ   = 4'd4,
        OP_AND   = 4'd5,
        OP_XORI  = 4'd6,
        OP_JMP   = 4'd7,
        OP_LSL   = 4'd8,
        OP_LSR   = 4'd9,
        OP_LOAD  = 4'd10,
        OP_STORE = 4'd11
    } t_opcode;

    // One result item
    typedef struct packed {
        logic [31:0]      mem_value;
        logic [IDX_W-1:0] mem_index;
        logic [31:0]      reg_value;
        logic [RF_AW-1:0] reg_index;
        logic [31:0]      pc_next;
        logic             mem_written;
        logic             reg_written;
        logic             executed;
    } t_result;

    // Register file write port
    typedef struct packed {
        logic             we;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } t_rf_wr;

    // Execute stage outcome
    typedef struct packed {
        logic [31:0]       res;
        logic              wr;
        logic [31:0]       pc_next;
        logic              is_load;
        logic              is_store;
        logic [MEM_AW-1:0] maddr;
        logic [IDX_W-1:0]  mindex;
        logic [31:0]       sval;
    } t_exec;

    // Instruction field decode
    function automatic t_opcode op_of(input logic [31:0] w);
        return t_opcode'(w[31:28]);
    endfunction

    function automatic logic [RF_AW-1:0] r1_of(input logic [31:0] w);
        return w[27:23];
    endfunction

    function automatic logic [RF_AW-1:0] r2_of(input logic [31:0] w);
        return w[22:18];
    endfunction

    function automatic logic [RF_AW-1:0] r3_of(input logic [31:0] w);
        return w[17:13];
    endfunction

    function automatic logic [31:0] imm_of(input logic [31:0] w);
        return {{14{w[17]}}, w[17:0]};
    endfunction

endpackage

// ----- hdl/rcis_wmem.sv -----
module rcis_wmem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rcis_pkg::MEM_AW-1:0] i_waddr,
    input  logic [31:0]                i_wdata,
    input  logic [rcis_pkg::MEM_AW-1:0] i_raddr,
    output logic [31:0]                o_rdata
);
    import rcis_pkg::*;

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rcis_rf.sv -----
module rcis_rf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rcis_pkg::RF_AW-1:0] i_ra_addr,
    input  logic [rcis_pkg::RF_AW-1:0] i_rb_addr,
    input  rcis_pkg::t_rf_wr           i_wr,
    output logic [31:0]                o_ra_data,
    output logic [31:0]                o_rb_data
);
    import rcis_pkg::*;

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]         r_ra;
    logic [31:0]         r_rb;
    logic                r_ra_v;
    logic                r_rb_v;

    // Storage and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_ra <= r_mem[i_ra_addr];
        r_rb <= r_mem[i_rb_addr];
    end

    // Written flags; an unwritten register reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ra_v  <= 1'b0;
            r_rb_v  <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_ra_v <= r_valid[i_ra_addr];
            r_rb_v <= r_valid[i_rb_addr];
        end
    end

    assign o_ra_data = r_ra_v ? r_ra : '0;
    assign o_rb_data = r_rb_v ? r_rb : '0;

endmodule

// ----- hdl/rcis_alu.sv -----
module rcis_alu (
    input  logic [31:0]     i_instr,
    input  logic [31:0]     i_a,
    input  logic [31:0]     i_b,
    input  logic [31:0]     i_pc,
    output rcis_pkg::t_exec o_exec
);
    import rcis_pkg::*;

    t_opcode     op;
    logic [31:0] imm;
    logic [12:0] shamt;
    logic [31:0] pc_inc;
    logic [31:0] sum_addr;
    logic [31:0] addr_m;
    logic [31:0] prod;

    always_comb begin
        op       = op_of(i_instr);
        imm      = imm_of(i_instr);
        shamt    = i_instr[12:0];
        pc_inc   = i_pc + 32'd1;
        sum_addr = i_a + imm;
        addr_m   = sum_addr & MEM_MASK;
        prod     = i_a * i_b;

        o_exec         = '0;
        o_exec.pc_next = pc_inc;
        o_exec.maddr   = addr_m[MEM_AW-1:0];
        o_exec.mindex  = addr_m[IDX_W-1:0];
        o_exec.sval    = i_b;

        // i_b carries R3 for ALU ops, R1 for compare and store
        case (op)
            OP_ADD: begin
                o_exec.res = i_a + i_b;
                o_exec.wr  = 1'b1;
            end
            OP_SUB: begin
                o_exec.res = i_a - i_b;
                o_exec.wr  = 1'b1;
            end
            OP_MUL: begin
                o_exec.res = prod;
                o_exec.wr  = 1'b1;
            end
            OP_MOVI: begin
                o_exec.res = imm;
                o_exec.wr  = 1'b1;
            end
            OP_JEQ: begin
                if (i_b == i_a) begin
                    o_exec.pc_next = pc_inc + imm;
                end
            end
            OP_AND: begin
                o_exec.res = i_a & i_b;
                o_exec.wr  = 1'b1;
            end
            OP_XORI: begin
                o_exec.res = i_a ^ imm;
                o_exec.wr  = 1'b1;
            end
            OP_JMP: begin
                o_exec.pc_next = {pc_inc[31:28], i_instr[27:0]};
            end
            OP_LSL: begin
                o_exec.res = (shamt < 13'(SHAMT_LIMIT)) ? (i_a << shamt[4:0]) : '0;
                o_exec.wr  = 1'b1;
            end
            OP_LSR: begin
                o_exec.res = (shamt < 13'(SHAMT_LIMIT)) ? (i_a >> shamt[4:0]) : '0;
                o_exec.wr  = 1'b1;
            end
            OP_LOAD: begin
                o_exec.is_load = 1'b1;
                o_exec.wr      = 1'b1;
            end
            OP_STORE: begin
                o_exec.is_store = 1'b1;
            end
            default: begin
                o_exec.wr = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/rcis_ofifo.sv -----
module rcis_ofifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rcis_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output rcis_pkg::t_result o_data
);
    import rcis_pkg::*;

    t_result             r_slot [OFIFO_DEPTH];
    logic [OFIFO_PW-1:0] r_wptr;
    logic [OFIFO_PW-1:0] r_rptr;
    logic [CNT_W-1:0]    r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];
    assign pop     = i_pop && o_valid;

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + OFIFO_PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + OFIFO_PW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/risc_core_instruction_step_unit.sv -----
// Instruction step unit of a small 32-bit core with a 2048-word unified memory.
// Input stream: tuser[0] selects the request (0 preload a memory word, 1 step
// one instruction at pc); tdata carries the preload address and word.
// Output stream: one result per request, in order: next pc, written register
// and its value, stored memory word, with the written flags in tuser.
// The program length register sets how many words may be executed; a step at
// or past it reports executed=0 and changes nothing.
// A preload completes in stage 1; halted, ALU, jump and store steps complete in
// stage 2 (execute); loads complete in stage 3, after the memory read.
// Throughput: preloads 1 per cycle while no step is in flight and the result
// queue has room. A step holds the input until it completes, as the fetch read is
// followed by the register file read; loads and stores use the memory port again.
// Reset clears pc, program length and the register file at once (per-register
// written flags); memory words are undefined until preloaded or stored.
// Results go through a two-entry queue; when it holds or awaits two results,
// tready drops until the receiver takes one. No result is ever dropped.
module risc_core_instruction_step_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Requests
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [47:0]                 i_s_axis_tdata,  // mem_addr[10:0], mem_data[42:11]
    input  logic [0:0]                  i_s_axis_tuser,  // req_type[0]
    // Results
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [111:0]                o_m_axis_tdata,  // pc_next[31:0], reg_index[36:32],
                                                         // reg_value[68:37], mem_index[79:69],
                                                         // mem_value[111:80]
    output logic [2:0]                  o_m_axis_tuser,  // executed[0], reg_written[1],
                                                         // mem_written[2]
    // Program length register
    input  logic                        i_cfg_we,
    input  logic [rcis_pkg::PLEN_W-1:0] i_cfg_wdata
);
    import rcis_pkg::*;

    // Architectural control state
    logic [31:0]       r_pc;
    logic [PLEN_W-1:0] r_plen;
    logic [CNT_W-1:0]  r_cnt;

    // Stage registers
    logic              r_s1_valid;
    logic              r_s1_pre;
    logic              r_s2_valid;
    logic              r_s2_halt;
    logic [31:0]       r_s2_instr;
    logic              r_s3_valid;
    logic [RF_AW-1:0]  r_s3_r1;

    logic              s_acc;
    logic              in_pre;
    logic [IDX_W-1:0]  in_addr;
    logic [31:0]       in_data;
    logic [31:0]       pre_full;
    logic [31:0]       wm_rdata;
    logic              wm_we;
    logic [MEM_AW-1:0] wm_waddr;
    logic [31:0]       wm_wdata;
    logic [MEM_AW-1:0] wm_raddr;
    logic              s1_halt;
    t_opcode           s1_op;
    logic [RF_AW-1:0]  rf_ra_addr;
    logic [RF_AW-1:0]  rf_rb_addr;
    logic [31:0]       rf_a;
    logic [31:0]       rf_b;
    t_rf_wr            rf_wr;
    t_exec             ex;
    logic [RF_AW-1:0]  s2_r1;
    logic              s2_exec;
    logic              s2_load;
    logic              s2_store;
    logic              s2_regw;
    logic              s1_done;
    logic              s2_done;
    logic              s3_done;
    logic              busy;
    logic              pipe_free;
    logic [31:0]       n_pc;
    logic              push;
    t_result           push_data;
    logic              fifo_valid;
    logic              fifo_pop;
    t_result           fifo_data;

    // Input unpacking
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_pre   = !i_s_axis_tuser[0];
    assign in_addr  = i_s_axis_tdata[10:0];
    assign in_data  = i_s_axis_tdata[42:11];
    assign pre_full = {{(32-IDX_W){1'b0}}, in_addr} & MEM_MASK;

    // Stage 1: fetched word is here; issue register reads
    assign s1_op      = op_of(wm_rdata);
    assign s1_halt    = !(r_pc < {{(32-PLEN_W){1'b0}}, r_plen});
    assign rf_ra_addr = r2_of(wm_rdata);
    assign rf_rb_addr = (s1_op == OP_JEQ || s1_op == OP_STORE) ? r1_of(wm_rdata)
                                                                : r3_of(wm_rdata);

    // Stage 2: execute
    rcis_alu u_alu (
        .i_instr (r_s2_instr),
        .i_a     (rf_a),
        .i_b     (rf_b),
        .i_pc    (r_pc),
        .o_exec  (ex)
    );

    assign s2_r1    = r1_of(r_s2_instr);
    assign s2_exec  = r_s2_valid && !r_s2_halt;
    assign s2_load  = s2_exec && ex.is_load;
    assign s2_store = s2_exec && ex.is_store;
    assign s2_regw  = s2_exec && ex.wr && !ex.is_load && (s2_r1 != '0);
    assign n_pc     = s2_exec ? ex.pc_next : r_pc;

    // Completion points; but for a store, the next request may enter on the same edge
    assign s1_done   = r_s1_valid && r_s1_pre;
    assign s2_done   = r_s2_valid && !s2_load;
    assign s3_done   = r_s3_valid;
    assign busy      = r_s1_valid || r_s2_valid || r_s3_valid;
    assign pipe_free = !busy || ((s1_done || s2_done || s3_done) && !s2_store);
    assign fifo_pop  = fifo_valid && i_m_axis_tready;
    assign o_s_axis_tready = pipe_free && ((r_cnt < CNT_W'(OFIFO_DEPTH)) || fifo_pop);

    // Word memory port steering
    assign wm_we    = (s_acc && in_pre) || s2_store;
    assign wm_waddr = s2_store ? ex.maddr : pre_full[MEM_AW-1:0];
    assign wm_wdata = s2_store ? ex.sval : in_data;
    assign wm_raddr = s2_load ? ex.maddr : n_pc[MEM_AW-1:0];

    rcis_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (wm_waddr),
        .i_wdata (wm_wdata),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    // Register file write-back from execute or from load return
    always_comb begin
        rf_wr.we   = s2_regw || (r_s3_valid && (r_s3_r1 != '0));
        rf_wr.addr = r_s3_valid ? r_s3_r1 : s2_r1;
        rf_wr.data = r_s3_valid ? wm_rdata : ex.res;
    end

    rcis_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ra_addr (rf_ra_addr),
        .i_rb_addr (rf_rb_addr),
        .i_wr      (rf_wr),
        .o_ra_data (rf_a),
        .o_rb_data (rf_b)
    );

    // Result assembly
    always_comb begin
        push_data         = '0;
        push_data.pc_next = r_pc;
        push              = s1_done || s2_done || s3_done;
        if (s3_done) begin
            push_data.executed    = 1'b1;
            push_data.reg_written = (r_s3_r1 != '0);
            if (r_s3_r1 != '0) begin
                push_data.reg_index = r_s3_r1;
                push_data.reg_value = wm_rdata;
            end
        end else if (s2_done && !r_s2_halt) begin
            push_data.pc_next     = ex.pc_next;
            push_data.executed    = 1'b1;
            push_data.reg_written = s2_regw;
            if (s2_regw) begin
                push_data.reg_index = s2_r1;
                push_data.reg_value = ex.res;
            end
            push_data.mem_written = ex.is_store;
            if (ex.is_store) begin
                push_data.mem_index = ex.mindex;
                push_data.mem_value = ex.sval;
            end
        end
    end

    rcis_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (i_m_axis_tready),
        .o_valid (fifo_valid),
        .o_data  (fifo_data)
    );

    assign o_m_axis_tvalid = fifo_valid;
    assign o_m_axis_tdata  = {fifo_data.mem_value, fifo_data.mem_index, fifo_data.reg_value,
                              fifo_data.reg_index, fifo_data.pc_next};
    assign o_m_axis_tuser  = {fifo_data.mem_written, fifo_data.reg_written,
                              fifo_data.executed};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_plen     <= '0;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            r_pc       <= n_pc;
            r_s1_valid <= s_acc;
            r_s2_valid <= r_s1_valid && !r_s1_pre;
            r_s3_valid <= s2_load;
            if (s_acc && !fifo_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!s_acc && fifo_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_s1_pre   <= in_pre;
        r_s2_halt  <= s1_halt;
        r_s2_instr <= wm_rdata;
        r_s3_r1    <= s2_r1;
    end

    // Only one request occupies the stages at a time
    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_s1_valid, r_s2_valid, r_s3_valid}))
        else $error("more than one stage valid");

    // Outstanding results never exceed the queue depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(OFIFO_DEPTH))
        else $error("result credit overflow");

    // A store owns the memory write port: no request enters with it
    a_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_store |-> !s_acc)
        else $error("request accepted during store");

    // Load return follows a load in execute
    a_load_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && s2_load |=> r_s3_valid && !r_s1_valid)
        else $error("load return out of sequence");

endmodule
